// ===== rtl/core/rwc_pkg.sv =====
// Shared types, constants and helpers for the realigning word copy block.
`timescale 1ns / 1ps
`default_nettype none

package rwc_pkg;

  localparam int WORD_BYTES = 8;
  localparam int LANE_W     = $clog2(WORD_BYTES);
  localparam int WORD_W     = WORD_BYTES * 8;
  localparam int HELD_W     = (WORD_BYTES - 1) * 8;
  localparam int COUNT_BITS = 20;

  // APB register map: one 32-bit register per word address
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_SRC_OFFSET = 2'd0;
  localparam logic [1:0] REG_DST_OFFSET = 2'd1;
  localparam logic [1:0] REG_BYTE_COUNT = 2'd2;

  // output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

  localparam logic [WORD_BYTES-1:0] ALL_LANES = '1;

  typedef struct packed {
    logic [WORD_W-1:0] src_word;
    logic              src_last;
  } src_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0]     dst_word;
    logic [WORD_BYTES-1:0] byte_enable;
    logic                  dst_last;
  } dst_beat_t;

  typedef struct packed {
    logic [2:0]            src_offset;
    logic [2:0]            dst_offset;
    logic [COUNT_BITS-1:0] byte_count;
  } cfg_t;

  // up to two result beats produced by one source beat, oldest in first
  typedef struct packed {
    logic [1:0] num;
    dst_beat_t  first;
    dst_beat_t  second;
  } push_t;

  // widen a lane mask to a bit mask, one byte per lane
  function automatic logic [WORD_W-1:0] lane_bits(input logic [WORD_BYTES-1:0] lanes);
    logic [WORD_W-1:0] bits;
    bits = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      bits[i*8 +: 8] = {8{lanes[i]}};
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rwc_cfg.sv =====
// APB register file for offsets and byte count.
`timescale 1ns / 1ps
`default_nettype none

module rwc_cfg
  import rwc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              armed,
  output cfg_t                   cfg
);

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  // writes land only between transfers
  assign wr     = psel & penable & pwrite & armed;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_SRC_OFFSET: cfg.src_offset <= pwdata[2:0];
        REG_DST_OFFSET: cfg.dst_offset <= pwdata[2:0];
        REG_BYTE_COUNT: cfg.byte_count <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SRC_OFFSET: prdata = 32'(cfg.src_offset);
      REG_DST_OFFSET: prdata = 32'(cfg.dst_offset);
      REG_BYTE_COUNT: prdata = 32'(cfg.byte_count);
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rwc_pack.sv =====
// Input register, byte packing logic and transfer state.
`timescale 1ns / 1ps
`default_nettype none

module rwc_pack
  import rwc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      src_valid,
  output logic           src_ready,
  input  wire src_beat_t src_beat,
  input  wire cfg_t      cfg,
  input  wire logic      room,
  output logic           armed,
  output push_t          push
);

  logic                  a_valid;
  src_beat_t             a_beat;
  logic                  fire;

  logic [HELD_W-1:0]     held;
  logic [LANE_W-1:0]     held_cnt;
  logic [COUNT_BITS-1:0] bytes_left;
  logic                  first_source;
  logic                  first_dest;

  logic [LANE_W-1:0]     lane;
  logic [COUNT_BITS-1:0] bl;
  logic [LANE_W:0]       avail;
  logic [LANE_W:0]       take;
  logic [WORD_BYTES-1:0] take_lanes;
  logic [WORD_W-1:0]     src_m;
  logic [2*WORD_W-1:0]   comb;
  logic [LANE_W:0]       total;
  logic [COUNT_BITS-1:0] bl_after;
  logic [LANE_W-1:0]     start;
  logic [LANE_W:0]       cap;
  logic                  e0;
  logic                  ended;
  logic [2*WORD_W-1:0]   rem_all;
  logic [WORD_W-1:0]     rem;
  logic [LANE_W:0]       rem_cnt;
  logic [LANE_W-1:0]     start1;
  logic [WORD_BYTES-1:0] rem_lanes;
  logic                  e1;
  dst_beat_t             r0;
  dst_beat_t             r1;

  // input register: refill while the current beat moves on
  assign fire      = a_valid & room;
  assign src_ready = ~a_valid | fire;
  assign armed     = first_source;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (src_ready) begin
      a_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      a_beat <= src_beat;
    end
  end

  always_comb begin
    lane       = first_source ? cfg.src_offset[LANE_W-1:0] : '0;
    bl         = first_source ? cfg.byte_count : bytes_left;
    avail      = (LANE_W+1)'(WORD_BYTES) - (LANE_W+1)'(lane);
    take       = (bl < COUNT_BITS'(avail)) ? bl[LANE_W:0] : avail;
    take_lanes = ~(ALL_LANES << take);
    src_m      = (a_beat.src_word >> {lane, 3'b000}) & lane_bits(take_lanes);
    comb       = (2*WORD_W)'(held) | ((2*WORD_W)'(src_m) << {held_cnt, 3'b000});
    total      = (LANE_W+1)'(held_cnt) + take;
    bl_after   = bl - COUNT_BITS'(take);

    // full (or head) destination word
    start      = first_dest ? cfg.dst_offset[LANE_W-1:0] : '0;
    cap        = (LANE_W+1)'(WORD_BYTES) - (LANE_W+1)'(start);
    e0         = (total >= cap);
    ended      = e0 && (bl_after == '0) && (total == cap);
    r0.dst_word    = comb[WORD_W-1:0] << {start, 3'b000};
    r0.byte_enable = ALL_LANES << start;
    r0.dst_last    = ended;

    // leftover bytes, or an empty closing word when the source ends early
    rem_all   = e0 ? (comb >> {cap, 3'b000}) : comb;
    rem       = rem_all[WORD_W-1:0];
    rem_cnt   = e0 ? (total - cap) : total;
    start1    = e0 ? '0 : start;
    rem_lanes = ~(ALL_LANES << rem_cnt);
    e1        = !ended &&
                (((rem_cnt != '0) && ((bl_after == '0) || a_beat.src_last)) ||
                 (a_beat.src_last && (bl_after != '0)));
    r1.dst_word    = (rem & lane_bits(rem_lanes)) << {start1, 3'b000};
    r1.byte_enable = rem_lanes << start1;
    r1.dst_last    = 1'b1;

    push.num    = fire ? (2'(e0) + 2'(e1)) : 2'd0;
    push.first  = e0 ? r0 : r1;
    push.second = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= '0;
      held_cnt     <= '0;
      bytes_left   <= '0;
      first_source <= 1'b1;
      first_dest   <= 1'b1;
    end else if (fire) begin
      if (a_beat.src_last) begin
        held         <= '0;
        held_cnt     <= '0;
        bytes_left   <= '0;
        first_source <= 1'b1;
        first_dest   <= 1'b1;
      end else begin
        held         <= e1 ? '0 : rem[HELD_W-1:0];
        held_cnt     <= e1 ? '0 : rem_cnt[LANE_W-1:0];
        bytes_left   <= bl_after;
        first_source <= 1'b0;
        first_dest   <= first_dest & ~(e0 | e1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rwc_outq.sv =====
// Small result queue that takes up to two beats per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rwc_outq
  import rwc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room,
  output logic       dst_valid,
  input  wire logic  dst_ready,
  output dst_beat_t  dst_beat
);

  dst_beat_t           mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_PTR_W:0]   count;
  logic                pop;

  assign pop       = dst_valid & dst_ready;
  assign dst_valid = (count != '0);
  assign dst_beat  = mem[rd_ptr];
  // room for a worst-case pair, judged on registered state only
  assign room      = (count <= (OQ_PTR_W+1)'(OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[OQ_PTR_W'(wr_ptr + 1'b1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push.num);
      rd_ptr <= rd_ptr + OQ_PTR_W'(pop);
      count  <= count + (OQ_PTR_W+1)'(push.num) - (OQ_PTR_W+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/realigning_word_copy.sv =====
// Top level of the realigning word copy block.
// Path: a source beat passes the input register, then the packing logic writes its
//   destination beats into the result queue, which presents them.
// Throughput: one source beat per cycle while the queue has room, set by the single-pass
//   packing logic; the source beat that uses up the count or carries src_last may give two.
// Reset (rst, synchronous): clears registers, queue and transfer state; block re-arms.
`timescale 1ns / 1ps
`default_nettype none

module realigning_word_copy
  import rwc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // source beats
  input  wire logic              src_valid,
  output logic                   src_ready,
  input  wire src_beat_t         src_beat,
  // destination beats
  output logic                   dst_valid,
  input  wire logic              dst_ready,
  output dst_beat_t              dst_beat,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t  cfg;
  logic  armed;
  logic  room;
  push_t push;

  // Registers: writes are dropped once a transfer has opened, until its
  // last source beat closes it.
  rwc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .armed   (armed),
    .cfg     (cfg)
  );

  // Packing: hold the beat in the input register, merge its live bytes after
  // the carried-over bytes, cut off a destination word when enough have
  // gathered, and flush the rest on the end of the count or of the source.
  rwc_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_beat  (src_beat),
    .cfg       (cfg),
    .room      (room),
    .armed     (armed),
    .push      (push)
  );

  // Result queue: parts the destination side from the packing logic, so a
  // stalled destination does not stop intake until fewer than two queue entries are free.
  rwc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_beat  (dst_beat)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rwc_checker.sv =====
// Port-level checker for the realigning word copy block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module rwc_checker
  import rwc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      dst_valid,
  input wire logic      dst_ready,
  input wire dst_beat_t dst_beat
);

  // no beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("destination beat valid after reset");

  // lanes without an enable carry zero
  a_lanes_clean: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> ((dst_beat.dst_word & ~lane_bits(dst_beat.byte_enable)) == '0))
    else $error("data in a disabled lane");

  // any beat before the last one runs up to the top lane
  a_mid_full: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_beat.dst_last |-> dst_beat.byte_enable[WORD_BYTES-1])
    else $error("non-final beat does not reach the top lane");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_beat))
    else $error("destination beat changed while stalled");

endmodule

bind realigning_word_copy rwc_checker u_rwc_checker (
  .clk       (clk),
  .rst       (rst),
  .dst_valid (dst_valid),
  .dst_ready (dst_ready),
  .dst_beat  (dst_beat)
);

`default_nettype wire
